// ===== hdl/idll_pkg.sv =====
// types and codes shared by the indexed doubly linked list block
`timescale 1ns / 1ps
package idll_pkg;

  typedef enum logic [2:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_INSERT     = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_POP_FRONT  = 3'd4,
    FN_ERASE_POS  = 3'd5,
    FN_ERASE_SLOT = 3'd6,
    FN_READ       = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_POOL_FULL = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_LINKED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_WALK_WAIT,
    S_TARGET,
    S_NBR_RD,
    S_NBR_WAIT,
    S_WRITE1,
    S_WRITE2,
    S_DONE
  } state_e;

endpackage

// ===== hdl/indexed_doubly_linked_list_top.sv =====
// indexed doubly linked list: link memories, flags and operation sequencer
//
//  channel   | direction | handshake          | payload
//  command   | in        | start_i / busy_o   | func_i position_i slot_index_i data_value_i
//  result    | out       | done_o (one cycle) | status_o slot_used_o prior_link_o
//            |           |                    | read_value_o list_length_o
//
// From the accepted beat to the done_o beat: an error found by the first
// checks ends the operation after those checks; a read, and erase slot on a
// slot that is not linked, end after the neighbour read; every other
// operation then writes both halves of its splice. A walk by position reads
// the next-link memory once per link followed and waits for each read.
// Reset clears the sequencer and counters; the head and tail sentinel links
// are held in registers and the linked flags sit in a memory that is only
// trusted below the allocation count, so no clearing pass is needed.
// busy_o is high from the cycle after the accepted beat until the done_o
// cycle, in which a new beat may be taken; the receiver cannot stall, so
// results leave on done_o whatever happens.
`timescale 1ns / 1ps
module indexed_doubly_linked_list_top #(
  parameter int POOL_SLOTS = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [10:0] position_i,
  input  logic [9:0]  slot_index_i,
  input  logic [31:0] data_value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [9:0]  slot_used_o,
  output logic [10:0] prior_link_o,
  output logic [31:0] read_value_o,
  output logic [10:0] list_length_o
);
  import idll_pkg::*;

  localparam int SW = $clog2(POOL_SLOTS);   // slot index bits
  localparam int LW = $clog2(POOL_SLOTS + 2); // link bits incl. sentinels
  localparam int CW = $clog2(POOL_SLOTS + 1); // count bits
  localparam logic [LW-1:0] HEAD = LW'(POOL_SLOTS);
  localparam logic [LW-1:0] TAIL = LW'(POOL_SLOTS + 1);

  // memories of the pool slots
  logic [VALUE_BITS-1:0] val_mem [POOL_SLOTS];
  logic [LW-1:0] nxt_mem [POOL_SLOTS];
  logic [LW-1:0] prv_mem [POOL_SLOTS];
  logic lnk_mem [POOL_SLOTS];

  // sentinel links in registers
  logic [LW-1:0] head_nxt_q, tail_prv_q;

  state_e state_q, state_d;
  func_e fn_q;
  logic [10:0] pos_q;
  logic [9:0] sidx_q;
  logic [VALUE_BITS-1:0] data_q;
  logic [CW-1:0] alloc_q, count_q;
  logic [CW-1:0] walk_q;
  logic [LW-1:0] cur_q;          // current node of walk / target
  logic [LW-1:0] bef_q, aft_q;   // neighbours
  logic [2:0] status_q;
  logic [9:0] used_q;
  logic [10:0] prior_q;
  logic [31:0] rval_q;
  logic done_q;

  // memory read ports
  logic [SW-1:0] rd_addr;
  logic [LW-1:0] nxt_rd_q, prv_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic lnk_rd_q;

  // write ports
  logic nw_en, pw_en, vw_en, lw_en;
  logic [SW-1:0] nw_addr, pw_addr, lw_addr;
  logic [LW-1:0] nw_data, pw_data;
  logic lw_data;

  logic is_push;
  logic slot_gone;
  logic [LW-1:0] link_nxt, link_prv; // link reads with sentinel lookup

  assign is_push = (fn_q == FN_PUSH_BACK) || (fn_q == FN_PUSH_FRONT) ||
                   (fn_q == FN_INSERT);

  // erase slot on an allocated slot that has since been unlinked
  assign slot_gone = (fn_q == FN_ERASE_SLOT) && !lnk_rd_q;

  // next link of cur_q (read issued the cycle before)
  assign link_nxt = (cur_q == HEAD) ? head_nxt_q : nxt_rd_q;
  assign link_prv = (cur_q == TAIL) ? tail_prv_q : prv_rd_q;

  // read address follows the node being looked at
  assign rd_addr = cur_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    nxt_rd_q <= nxt_mem[rd_addr];
    prv_rd_q <= prv_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
    lnk_rd_q <= lnk_mem[rd_addr];
    if (nw_en) nxt_mem[nw_addr] <= nw_data;
    if (pw_en) prv_mem[pw_addr] <= pw_data;
    if (vw_en) val_mem[alloc_q[SW-1:0]] <= data_q;
    if (lw_en) lnk_mem[lw_addr] <= lw_data;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (start_i) state_d = S_CHECK;
      S_CHECK:     state_d = S_WALK;
      S_WALK:      state_d = (status_q != ST_OK) ? S_DONE :
                             (walk_q == '0) ? S_TARGET : S_WALK_WAIT;
      S_WALK_WAIT: state_d = S_WALK;
      S_TARGET:    state_d = S_NBR_RD;
      S_NBR_RD:    state_d = S_NBR_WAIT;
      S_NBR_WAIT:  state_d = (fn_q == FN_READ || slot_gone) ? S_DONE : S_WRITE1;
      S_WRITE1:    state_d = S_WRITE2;
      S_WRITE2:    state_d = S_DONE;
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // link writes: first and second half of a splice
  always_comb begin
    nw_en = 1'b0; pw_en = 1'b0; vw_en = 1'b0; lw_en = 1'b0;
    nw_addr = '0; pw_addr = '0; nw_data = '0; pw_data = '0;
    lw_addr = '0; lw_data = 1'b0;
    if (state_q == S_WRITE1) begin
      if (is_push) begin
        // new slot links between bef and aft
        nw_en = 1'b1; nw_addr = alloc_q[SW-1:0]; nw_data = aft_q;
        pw_en = 1'b1; pw_addr = alloc_q[SW-1:0]; pw_data = bef_q;
        vw_en = 1'b1;
        lw_en = 1'b1; lw_addr = alloc_q[SW-1:0]; lw_data = 1'b1;
      end
    end else if (state_q == S_WRITE2) begin
      if (is_push) begin
        nw_en = (bef_q != HEAD); nw_addr = bef_q[SW-1:0];
        nw_data = LW'(alloc_q);
        pw_en = (aft_q != TAIL); pw_addr = aft_q[SW-1:0];
        pw_data = LW'(alloc_q);
      end else begin
        nw_en = (bef_q != HEAD); nw_addr = bef_q[SW-1:0]; nw_data = aft_q;
        pw_en = (aft_q != TAIL); pw_addr = aft_q[SW-1:0]; pw_data = bef_q;
        lw_en = 1'b1; lw_addr = cur_q[SW-1:0]; lw_data = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      count_q <= '0;
      head_nxt_q <= TAIL;
      tail_prv_q <= HEAD;
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_DONE);
      if (state_q == S_WRITE2) begin
        if (is_push) begin
          if (bef_q == HEAD) head_nxt_q <= LW'(alloc_q);
          if (aft_q == TAIL) tail_prv_q <= LW'(alloc_q);
          alloc_q <= alloc_q + 1'b1;
          count_q <= count_q + 1'b1;
        end else begin
          if (bef_q == HEAD) head_nxt_q <= aft_q;
          if (aft_q == TAIL) tail_prv_q <= bef_q;
          count_q <= count_q - 1'b1;
        end
      end
    end
  end

  // operation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (start_i) begin
        fn_q <= func_e'(func_i);
        pos_q <= position_i;
        sidx_q <= slot_index_i;
        data_q <= VALUE_BITS'(data_value_i);
        status_q <= ST_OK;
        used_q <= '0; prior_q <= '0; rval_q <= '0;
      end
      S_CHECK: begin
        // error checks and starting node
        walk_q <= '0;
        cur_q <= head_nxt_q;
        if (is_push) begin
          if (alloc_q >= CW'(POOL_SLOTS)) status_q <= ST_POOL_FULL;
          else if (fn_q == FN_INSERT && {1'b0, pos_q} > 12'(count_q))
            status_q <= ST_BAD_POS;
          if (fn_q == FN_PUSH_BACK) cur_q <= TAIL;
          if (fn_q == FN_INSERT) walk_q <= CW'(pos_q);
        end else if (fn_q == FN_ERASE_SLOT) begin
          // slots at or past the allocation count were never linked
          cur_q <= LW'(sidx_q);
          if (32'(sidx_q) >= 32'(POOL_SLOTS) || 32'(sidx_q) >= 32'(alloc_q))
            status_q <= ST_NOT_LINKED;
        end else begin
          if (count_q == '0) status_q <= ST_EMPTY;
          else if ((fn_q == FN_ERASE_POS || fn_q == FN_READ) &&
                   {1'b0, pos_q} >= 12'(count_q))
            status_q <= ST_BAD_POS;
          if (fn_q == FN_POP_BACK) cur_q <= tail_prv_q;
          if (fn_q == FN_ERASE_POS || fn_q == FN_READ) walk_q <= CW'(pos_q);
        end
      end
      S_WALK: if (walk_q != '0) walk_q <= walk_q - 1'b1;
      S_WALK_WAIT: cur_q <= link_nxt;
      S_NBR_WAIT: begin
        // neighbours of the target
        if (is_push) begin
          aft_q <= cur_q;
          bef_q <= link_prv;
          used_q <= 10'(alloc_q[SW-1:0]);
        end else if (slot_gone) begin
          status_q <= ST_NOT_LINKED;
        end else begin
          bef_q <= prv_rd_q;
          aft_q <= nxt_rd_q;
          used_q <= 10'(cur_q[SW-1:0]);
          rval_q <= 32'(val_rd_q);
          if (fn_q != FN_READ) prior_q <= 11'(prv_rd_q);
        end
      end
      default: ;
    endcase
  end

  // outputs
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign status_o = status_q;
  assign slot_used_o = used_q;
  assign prior_link_o = prior_q;
  assign read_value_o = rval_q;
  assign list_length_o = 11'(count_q);

  // checks
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= alloc_q) else $error("length beyond allocations");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_DONE) else $error("stray done");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> $stable(count_q)) else $error("error changed state");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("beat not taken");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the indexed doubly linked list block
`timescale 1ns / 1ps
module testbench;
  import idll_pkg::*;

  localparam int SLOTS = 1024;
  localparam int HEAD = SLOTS;
  localparam int TAIL = SLOTS + 1;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    func_e       fn;
    logic [10:0] pos;
    logic [9:0]  slot;
    logic [31:0] data;
  } cmd_t;

  typedef struct {
    status_e     status;
    logic [9:0]  slot;
    logic [10:0] prior;
    logic [31:0] value;
    logic [10:0] length;
  } res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  func_i;
  logic [10:0] position_i;
  logic [9:0]  slot_index_i;
  logic [31:0] data_value_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [9:0]  slot_used_o;
  logic [10:0] prior_link_o;
  logic [31:0] read_value_o;
  logic [10:0] list_length_o;

  indexed_doubly_linked_list_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .position_i, .slot_index_i,
    .data_value_i, .done_o, .status_o, .slot_used_o, .prior_link_o,
    .read_value_o, .list_length_o
  );

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // shadow copy of the list
  logic [10:0] nxt_link [0:SLOTS+1];
  logic [10:0] prv_link [0:SLOTS+1];
  logic [31:0] slot_value [0:SLOTS-1];
  bit          slot_linked [0:SLOTS-1];
  int          slots_handed;
  int          entries;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   total_cmds;
  int   beats_sent;
  int   results_seen = 0;
  int   mismatches = 0;
  int   stall_cycles = 0;

  function automatic int slot_at(int p);
    int s;
    s = int'(nxt_link[HEAD]);
    for (int i = 0; i < p; i++) s = int'(nxt_link[s]);
    return s;
  endfunction

  function automatic void unlink(int s, ref res_t r);
    int b;
    int a;
    b = int'(prv_link[s]);
    a = int'(nxt_link[s]);
    nxt_link[b] = 11'(a);
    prv_link[a] = 11'(b);
    slot_linked[s] = 0;
    entries--;
    r.slot = 10'(s);
    r.prior = 11'(b);
    r.value = slot_value[s];
  endfunction

  // predicts one result and advances the shadow list
  function automatic res_t apply_list_op(cmd_t c);
    res_t r;
    int   at;
    int   b;
    r = '{ST_OK, '0, '0, '0, '0};
    case (c.fn)
      FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT: begin
        if (slots_handed >= SLOTS) r.status = ST_POOL_FULL;
        else if (c.fn == FN_INSERT && c.pos > entries) r.status = ST_BAD_POS;
        else begin
          if (c.fn == FN_PUSH_BACK) at = TAIL;
          else if (c.fn == FN_PUSH_FRONT) at = int'(nxt_link[HEAD]);
          else at = slot_at(int'(c.pos));
          b = int'(prv_link[at]);
          slot_value[slots_handed] = c.data;
          prv_link[slots_handed] = 11'(b);
          nxt_link[b] = 11'(slots_handed);
          nxt_link[slots_handed] = 11'(at);
          prv_link[at] = 11'(slots_handed);
          slot_linked[slots_handed] = 1;
          r.slot = 10'(slots_handed);
          slots_handed++;
          entries++;
        end
      end
      FN_ERASE_SLOT: begin
        if (!slot_linked[c.slot]) r.status = ST_NOT_LINKED;
        else unlink(int'(c.slot), r);
      end
      default: begin
        if (entries == 0) r.status = ST_EMPTY;
        else if (c.fn == FN_POP_BACK) unlink(int'(prv_link[TAIL]), r);
        else if (c.fn == FN_POP_FRONT) unlink(int'(nxt_link[HEAD]), r);
        else if (c.pos >= entries) r.status = ST_BAD_POS;
        else if (c.fn == FN_READ) begin
          at = slot_at(int'(c.pos));
          r.slot = 10'(at);
          r.value = slot_value[at];
        end else unlink(slot_at(int'(c.pos)), r);
      end
    endcase
    r.length = 11'(entries);
    return r;
  endfunction

  function automatic void queue_cmd(func_e fn, int pos, int slot, logic [31:0] data);
    cmd_t c;
    c = '{fn, pos[10:0], slot[9:0], data};
    pending_cmds.insert(pending_cmds.size(), c);
    expected_results.insert(expected_results.size(), apply_list_op(c));
    total_cmds++;
  endfunction

  // a position that is mostly in range, sometimes any 11-bit value
  function automatic int pick_pos(int span);
    if ($urandom_range(0, 9) == 0 || span == 0) return $urandom_range(0, 2047);
    return $urandom_range(0, span - 1);
  endfunction

  // stimulus: directed cases, random mix, then fill the pool
  initial begin
    func_e fn;
    int    r;
    slots_handed = 0;
    entries = 0;
    total_cmds = 0;
    for (int i = 0; i < SLOTS + 2; i++) begin
      nxt_link[i] = '0;
      prv_link[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      slot_linked[i] = 0;
      slot_value[i] = '0;
    end
    nxt_link[HEAD] = 11'(TAIL);
    prv_link[TAIL] = 11'(HEAD);

    // empty list errors
    queue_cmd(FN_POP_BACK, 0, 0, '0);
    queue_cmd(FN_POP_FRONT, 0, 0, '0);
    queue_cmd(FN_ERASE_POS, 0, 0, '0);
    queue_cmd(FN_READ, 0, 0, '0);
    queue_cmd(FN_ERASE_SLOT, 0, 0, '0);
    queue_cmd(FN_INSERT, 1, 0, 32'h1);
    // building up, extremes of data
    queue_cmd(FN_INSERT, 0, 0, 32'h1234_5678);
    queue_cmd(FN_PUSH_BACK, 0, 0, 32'h0);
    queue_cmd(FN_PUSH_FRONT, 0, 0, 32'hFFFF_FFFF);
    queue_cmd(FN_INSERT, 3, 0, 32'hA5A5_A5A5);
    queue_cmd(FN_INSERT, 2, 1023, 32'h5A5A_5A5A);
    queue_cmd(FN_INSERT, 2047, 0, 32'h0);
    for (int p = 0; p < 5; p++) queue_cmd(FN_READ, p, 0, '0);
    queue_cmd(FN_READ, 5, 0, '0);
    queue_cmd(FN_READ, 2047, 0, '0);
    queue_cmd(FN_ERASE_POS, 2, 0, '0);
    queue_cmd(FN_ERASE_POS, 1024, 0, '0);
    queue_cmd(FN_ERASE_SLOT, 1, 0, '0);
    queue_cmd(FN_ERASE_SLOT, 1, 0, '0);
    queue_cmd(FN_ERASE_SLOT, 1023, 0, '0);
    queue_cmd(FN_POP_BACK, 0, 0, '0);
    queue_cmd(FN_POP_FRONT, 0, 0, '0);

    // random mix, sized so that filling the pool brings the run to its total
    while (total_cmds + (SLOTS - slots_handed) < 1130) begin
      r = $urandom_range(0, 99);
      if (r < (entries > 48 ? 25 : 55)) begin
        fn = func_e'($urandom_range(FN_PUSH_BACK, FN_INSERT));
        queue_cmd(fn, fn == FN_INSERT ? pick_pos(entries + 1) : $urandom_range(0, 2047),
                  $urandom_range(0, 1023), $urandom());
      end else if (r < 88) begin
        fn = func_e'($urandom_range(FN_POP_BACK, FN_ERASE_SLOT));
        queue_cmd(fn, pick_pos(entries),
                  ($urandom_range(0, 6) == 0 || entries == 0) ?
                    $urandom_range(0, 1023) : slot_at($urandom_range(0, entries - 1)),
                  $urandom());
      end else begin
        queue_cmd(FN_READ, pick_pos(entries), $urandom_range(0, 1023), $urandom());
      end
    end

    // use up the pool, then hit the full case on every allocating operation
    while (slots_handed < SLOTS) queue_cmd(FN_PUSH_BACK, 0, 0, $urandom());
    queue_cmd(FN_PUSH_BACK, 0, 0, $urandom());
    queue_cmd(FN_PUSH_FRONT, 0, 0, $urandom());
    queue_cmd(FN_INSERT, 2047, 0, $urandom());
    queue_cmd(FN_INSERT, 0, 0, $urandom());
    queue_cmd(FN_READ, 0, 0, '0);
    // long walks down the list, then removals at both ends
    queue_cmd(FN_READ, entries - 1, 0, '0);
    queue_cmd(FN_ERASE_POS, entries / 2, 0, '0);
    queue_cmd(FN_ERASE_SLOT, SLOTS - 1, 0, '0);
    queue_cmd(FN_POP_BACK, 0, 0, '0);
    queue_cmd(FN_POP_FRONT, 0, 0, '0);
    queue_cmd(FN_INSERT, 0, 0, $urandom());
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // command driver; sender gaps change with progress through the run
  always @(posedge clk_i or negedge rst_ni) begin
    int idle_pct;
    cmd_t c;
    if (!rst_ni) begin
      start_i <= 1'b0;
      func_i <= FN_PUSH_BACK;
      position_i <= '0;
      slot_index_i <= '0;
      data_value_i <= '0;
      beats_sent <= 0;
    end else begin
      idle_pct = beats_sent < total_cmds / 3 ? 14 :
                 beats_sent < 2 * total_cmds / 3 ? 83 : 0;
      if (start_i && !busy_o) beats_sent <= beats_sent + 1;
      if (!start_i || !busy_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          c = pending_cmds[0];
          pending_cmds.delete(0);
          start_i <= 1'b1;
          func_i <= c.fn;
          position_i <= c.pos;
          slot_index_i <= c.slot;
          data_value_i <= c.data;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", status_o);
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        if (status_o !== e.status || slot_used_o !== e.slot || prior_link_o !== e.prior ||
            read_value_o !== e.value || list_length_o !== e.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: exp st %0d slot %0d prior %0d val %h len %0d, got st %0d slot %0d prior %0d val %h len %0d",
                     results_seen, e.status, e.slot, e.prior, e.value, e.length,
                     status_o, slot_used_o, prior_link_o, read_value_o, list_length_o);
        end
      end
    end
  end

  // watchdog on cycles with no beat either way
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("testbench failed");
      $finish;
    end
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (pending_cmds.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("%0d commands over all eight operations, %0d results checked", total_cmds,
             results_seen);
    $display("pool slots handed out: %0d, mismatches: %0d", slots_handed, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
